/* hdl/srecord_line_parser_macros.svh */
// ----------------------------------------------------------------------------
// S-record line parser assertion macros
// Shared concurrent assertion forms used by the parser checker.
// ----------------------------------------------------------------------------
`ifndef SRECORD_LINE_PARSER_MACROS_SVH
`define SRECORD_LINE_PARSER_MACROS_SVH

// Implication checked in the clock after the antecedent.
`define SRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked in the same clock as the antecedent.
`define SRL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the clock after the antecedent, including reset cycles.
`define SRL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/srl_pkg.sv */
// ----------------------------------------------------------------------------
// S-record line parser package
// Types, codes and character decode helpers shared by the parser files.
// ----------------------------------------------------------------------------
package srl_pkg;

  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_HDR   = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_BAD_LEN  = 3'd3;
  localparam logic [2:0] ST_CSUM     = 3'd4;
  localparam logic [2:0] ST_BAD_HEX  = 3'd5;
  localparam logic [2:0] ST_TRUNC    = 3'd6;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_TYPE  = 6'b000010,
    PH_COUNT = 6'b000100,
    PH_ADDR  = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CSUM  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_start;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [3:0]  record_type;
    logic [31:0] load_address;
    logic [7:0]  data_count;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic       is_s;
    logic       is_eol;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       type_ok;
    logic [3:0] type_val;
    logic [2:0] addr_len;
  } srl_dec_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } srl_res_t;

  function automatic logic [2:0] addr_len_of(input logic [3:0] t);
    logic [2:0] len;
    unique case (t)
      4'd0, 4'd1, 4'd9: len = 3'd2;
      4'd2, 4'd8:       len = 3'd3;
      4'd3, 4'd7:       len = 3'd4;
      default:          len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

/* hdl/srl_in_if.sv */
// ----------------------------------------------------------------------------
// S-record character channel
// Valid/ready channel carrying one line character per transaction.
// ----------------------------------------------------------------------------
interface srl_in_if;
  import srl_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/srl_out_if.sv */
// ----------------------------------------------------------------------------
// S-record result channel
// Valid/ready channel carrying one data byte or record summary per transaction.
// ----------------------------------------------------------------------------
interface srl_out_if;
  import srl_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/srl_decode.sv */
// ----------------------------------------------------------------------------
// S-record character decoder
// Classifies one character: header, line end, hex digit, record type digit.
// ----------------------------------------------------------------------------
module srl_decode (
  input  logic [7:0]       char_code,
  output srl_pkg::srl_dec_t dec
);
  import srl_pkg::*;

  logic [7:0] dig_off;
  logic [7:0] up_off;
  logic [7:0] lo_off;
  logic       is_dig;
  logic       is_up;
  logic       is_lo;

  assign dig_off = char_code - 8'h30;
  assign up_off  = char_code - 8'h41;
  assign lo_off  = char_code - 8'h61;
  assign is_dig  = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_up   = (char_code >= 8'h41) && (char_code <= 8'h46);
  assign is_lo   = (char_code >= 8'h61) && (char_code <= 8'h66);

  always_comb begin
    dec.is_s     = (char_code == CHAR_S);
    dec.is_eol   = (char_code == CHAR_CR) || (char_code == CHAR_LF);
    dec.is_hex   = is_dig || is_up || is_lo;
    priority if (is_dig) begin
      dec.hex_val = dig_off[3:0];
    end else if (is_up) begin
      dec.hex_val = up_off[3:0] + 4'd10;
    end else begin
      dec.hex_val = lo_off[3:0] + 4'd10;
    end
    dec.type_val = dig_off[3:0];
    dec.addr_len = is_dig ? addr_len_of(dig_off[3:0]) : 3'd0;
    dec.type_ok  = (dec.addr_len != 3'd0);
  end
endmodule

/* hdl/srl_core.sv */
// ----------------------------------------------------------------------------
// S-record record state machine
// Tracks record fields, checksum and counts; forms any result for each char.
// ----------------------------------------------------------------------------
module srl_core #(
  parameter int MAX_DATA = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              line_start,
  input  srl_pkg::srl_dec_t dec,
  output srl_pkg::srl_res_t res
);
  import srl_pkg::*;

  localparam logic [7:0] MaxData = 8'(MAX_DATA);

  phase_t      phase, phase_next;
  logic [3:0]  type_held, type_held_next;
  logic [2:0]  addr_left, addr_left_next;
  logic [31:0] addr_held, addr_held_next;
  logic [7:0]  sum_held, sum_held_next;
  logic [7:0]  data_left, data_left_next;
  logic [7:0]  data_index, data_index_next;
  logic [7:0]  count_held, count_held_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        pending, pending_next;

  logic [7:0] byte_val;
  logic [7:0] overhead;
  logic [7:0] dlen;
  logic [7:0] sum_add;
  logic [2:0] addr_dec;
  logic [7:0] data_dec;

  assign byte_val = {high_nibble, dec.hex_val};
  assign overhead = {5'd0, addr_left} + 8'd1;
  assign dlen     = byte_val - overhead;
  assign sum_add  = sum_held + byte_val;
  assign addr_dec = (addr_left != 3'd0) ? addr_left - 3'd1 : 3'd0;
  assign data_dec = (data_left != 8'd0) ? data_left - 8'd1 : 8'd0;

  always_comb begin
    phase_next       = phase;
    type_held_next   = type_held;
    addr_left_next   = addr_left;
    addr_held_next   = addr_held;
    sum_held_next    = sum_held;
    data_left_next   = data_left;
    data_index_next  = data_index;
    count_held_next  = count_held;
    high_nibble_next = high_nibble;
    pending_next     = pending;

    res.valid             = 1'b0;
    res.item.kind         = KIND_SUMMARY;
    res.item.data_byte    = 8'd0;
    res.item.byte_index   = 8'd0;
    res.item.record_type  = type_held;
    res.item.load_address = addr_held;
    res.item.data_count   = data_index;
    res.item.status       = ST_OK;

    if (line_start) begin
      if (phase != PH_IDLE) begin
        res.valid       = 1'b1;
        res.item.status = ST_TRUNC;
      end
      type_held_next   = 4'd0;
      addr_left_next   = 3'd0;
      addr_held_next   = 32'd0;
      sum_held_next    = 8'd0;
      data_left_next   = 8'd0;
      data_index_next  = 8'd0;
      count_held_next  = 8'd0;
      high_nibble_next = 4'd0;
      pending_next     = 1'b0;
      if (dec.is_s) begin
        phase_next = PH_TYPE;
      end else begin
        phase_next = PH_IDLE;
        if (phase == PH_IDLE) begin
          res.valid             = 1'b1;
          res.item.record_type  = 4'd0;
          res.item.load_address = 32'd0;
          res.item.data_count   = 8'd0;
          res.item.status       = ST_NO_HDR;
        end
      end
    end else if (phase != PH_IDLE) begin
      priority if (dec.is_eol) begin
        res.valid       = 1'b1;
        res.item.status = ST_TRUNC;
        phase_next      = PH_IDLE;
      end else if (phase == PH_TYPE) begin
        if (dec.type_ok) begin
          type_held_next = dec.type_val;
          addr_left_next = dec.addr_len;
          phase_next     = PH_COUNT;
        end else begin
          res.valid       = 1'b1;
          res.item.status = ST_BAD_TYPE;
          phase_next      = PH_IDLE;
        end
      end else if (!dec.is_hex) begin
        res.valid       = 1'b1;
        res.item.status = ST_BAD_HEX;
        phase_next      = PH_IDLE;
      end else if (!pending) begin
        high_nibble_next = dec.hex_val;
        pending_next     = 1'b1;
      end else begin
        pending_next = 1'b0;
        unique case (phase)
          PH_COUNT: begin
            if ((byte_val < overhead) || (dlen > MaxData)) begin
              res.valid       = 1'b1;
              res.item.status = ST_BAD_LEN;
              phase_next      = PH_IDLE;
            end else begin
              count_held_next = dlen;
              data_left_next  = dlen;
              sum_held_next   = byte_val;
              phase_next      = PH_ADDR;
            end
          end
          PH_ADDR: begin
            addr_held_next = {addr_held[23:0], byte_val};
            sum_held_next  = sum_add;
            addr_left_next = addr_dec;
            if (addr_dec == 3'd0) begin
              phase_next = (data_left != 8'd0) ? PH_DATA : PH_CSUM;
            end
          end
          PH_DATA: begin
            sum_held_next       = sum_add;
            res.valid           = 1'b1;
            res.item.kind       = KIND_DATA;
            res.item.data_byte  = byte_val;
            res.item.byte_index = data_index;
            res.item.data_count = count_held;
            data_index_next     = data_index + 8'd1;
            data_left_next      = data_dec;
            if (data_dec == 8'd0) begin
              phase_next = PH_CSUM;
            end
          end
          PH_CSUM: begin
            res.valid       = 1'b1;
            res.item.status = (byte_val == ~sum_held) ? ST_OK : ST_CSUM;
            phase_next      = PH_IDLE;
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      type_held   <= 4'd0;
      addr_left   <= 3'd0;
      addr_held   <= 32'd0;
      sum_held    <= 8'd0;
      data_left   <= 8'd0;
      data_index  <= 8'd0;
      count_held  <= 8'd0;
      high_nibble <= 4'd0;
      pending     <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      type_held   <= type_held_next;
      addr_left   <= addr_left_next;
      addr_held   <= addr_held_next;
      sum_held    <= sum_held_next;
      data_left   <= data_left_next;
      data_index  <= data_index_next;
      count_held  <= count_held_next;
      high_nibble <= high_nibble_next;
      pending     <= pending_next;
    end
  end
endmodule

/* hdl/srl_out.sv */
// ----------------------------------------------------------------------------
// S-record result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module srl_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  srl_pkg::srl_res_t   res,
  output logic                in_ready,
  output logic                valid,
  input  logic                ready,
  output srl_pkg::out_item_t  payload
);
  import srl_pkg::*;

  logic valid_next;

  assign in_ready = !valid || ready;

  always_comb begin
    priority if (accept && res.valid) begin
      valid_next = 1'b1;
    end else if (ready) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      payload <= res.item;
    end
  end
endmodule

/* hdl/srecord_line_parser.sv */
// One character is taken per clock while the output register can accept; its
// result, if any, is in the output register the cycle after the character transaction.
// Sustained rate: one character per cycle, limited only by result back-pressure.
// Synchronous active-high reset returns the parser to waiting for a header
// and clears all record state and the output valid flag.
// ----------------------------------------------------------------------------
// S-record line parser
// Decodes S-record lines into data bytes and end-of-record summaries.
// ----------------------------------------------------------------------------
module srecord_line_parser #(
  parameter int MAX_DATA = 64
) (
  input logic       clk,
  input logic       rst,
  srl_in_if.sink    chars,
  srl_out_if.source results
);
  import srl_pkg::*;

  srl_dec_t dec;
  srl_res_t res;
  logic     in_ready;
  logic     accept;

  assign chars.ready = in_ready;
  assign accept      = chars.valid && in_ready;

  srl_decode u_decode (
    .char_code (chars.payload.char_code),
    .dec       (dec)
  );

  srl_core #(
    .MAX_DATA (MAX_DATA)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .line_start (chars.payload.line_start),
    .dec        (dec),
    .res        (res)
  );

  srl_out u_out (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .res      (res),
    .in_ready (in_ready),
    .valid    (results.valid),
    .ready    (results.ready),
    .payload  (results.payload)
  );
endmodule

/* hdl/srl_checker.sv */
// ----------------------------------------------------------------------------
// S-record line parser checker
// Port-level assertions on the parser channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "srecord_line_parser_macros.svh"

module srl_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input srl_pkg::out_item_t out_payload
);
  import srl_pkg::*;

  `SRL_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "result after reset")
  `SRL_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_payload), "stalled result changed")
  `SRL_ASSERT_SAME(a_ready_free, clk, rst, !out_valid, in_ready, "not ready with empty output")
  `SRL_ASSERT_SAME(a_data_ok, clk, rst, out_valid && (out_payload.kind == KIND_DATA), out_payload.status == ST_OK, "data byte with nonzero status")
  `SRL_ASSERT_NEXT(a_cause, clk, rst, !(in_valid && in_ready) && !(out_valid && !out_ready), !out_valid, "result without a character transaction")
endmodule

bind srecord_line_parser srl_checker u_srl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (chars.valid),
  .in_ready    (chars.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_payload (results.payload)
);

/* sim/srecord_line_parser_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// S-record line parser testbench
// Feeds directed and random S-record lines one character per transaction,
// predicts every data byte and record summary, and compares each result
// transaction field by field under random gaps and back-pressure.
// ----------------------------------------------------------------------------
module srecord_line_parser_test;
  import srl_pkg::*;

  localparam int MAX_DATA_BYTES = 64;
  localparam int CHAR_TARGET    = 830;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int REPORT_LIMIT   = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  srl_in_if  chars ();
  srl_out_if results ();

  srecord_line_parser #(.MAX_DATA(MAX_DATA_BYTES)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_item_t    pending_chars[$];
  out_item_t   awaited_results[$];
  logic [7:0]  line_buf[$];

  int chars_total;
  int chars_accepted;
  int error_count;
  int idle_cycles;
  int calm_left;
  int gap_left;
  int stall_left;
  bit char_accepted;

  // parser state mirror
  phase_t      line_phase = PH_IDLE;
  logic [3:0]  rec_type;
  logic [2:0]  addr_left;
  logic [31:0] rec_address;
  logic [7:0]  rec_sum;
  logic [7:0]  data_left;
  logic [7:0]  data_pos;
  logic [7:0]  data_total;
  logic [3:0]  hi_nibble;
  logic        nibble_held;

  function automatic int address_length(int t);
    case (t)
      0, 1, 9: return 2;
      2, 8:    return 3;
      3, 7:    return 4;
      default: return 0;
    endcase
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic void clear_record();
    rec_type = '0;
    addr_left = '0;
    rec_address = '0;
    rec_sum = '0;
    data_left = '0;
    data_pos = '0;
    data_total = '0;
    hi_nibble = '0;
    nibble_held = 1'b0;
  endfunction

  function automatic void emit(logic kind, logic [7:0] b, logic [7:0] idx,
                               logic [7:0] cnt, logic [2:0] st);
    out_item_t r;
    r.kind = kind;
    r.data_byte = b;
    r.byte_index = idx;
    r.record_type = rec_type;
    r.load_address = rec_address;
    r.data_count = cnt;
    r.status = st;
    awaited_results.push_back(r);
  endfunction

  function automatic void close_record(logic [2:0] st);
    emit(KIND_SUMMARY, 8'd0, 8'd0, data_pos, st);
    line_phase = PH_IDLE;
  endfunction

  function automatic void decode_char(in_item_t it);
    logic [7:0] c;
    logic [7:0] b;
    int h;
    int al;
    int overhead;
    bit emitted;
    c = it.char_code;
    if (it.line_start) begin
      emitted = 1'b0;
      if (line_phase != PH_IDLE) begin
        close_record(ST_TRUNC);
        emitted = 1'b1;
      end
      clear_record();
      if (c == CHAR_S) begin
        line_phase = PH_TYPE;
      end else begin
        line_phase = PH_IDLE;
        if (!emitted) emit(KIND_SUMMARY, 8'd0, 8'd0, 8'd0, ST_NO_HDR);
      end
      return;
    end
    if (line_phase == PH_IDLE) return;
    if (c == CHAR_CR || c == CHAR_LF) begin
      close_record(ST_TRUNC);
      return;
    end
    if (line_phase == PH_TYPE) begin
      al = (c >= "0" && c <= "9") ? address_length(c - "0") : 0;
      if (al == 0) begin
        close_record(ST_BAD_TYPE);
        return;
      end
      rec_type = 4'(c - "0");
      addr_left = 3'(al);
      line_phase = PH_COUNT;
      return;
    end
    h = hex_value(c);
    if (h < 0) begin
      close_record(ST_BAD_HEX);
      return;
    end
    if (!nibble_held) begin
      hi_nibble = 4'(h);
      nibble_held = 1'b1;
      return;
    end
    nibble_held = 1'b0;
    b = {hi_nibble, h[3:0]};
    case (line_phase)
      PH_COUNT: begin
        overhead = int'(addr_left) + 1;
        if (int'(b) < overhead || int'(b) - overhead > MAX_DATA_BYTES) begin
          close_record(ST_BAD_LEN);
        end else begin
          data_total = 8'(int'(b) - overhead);
          data_left = data_total;
          rec_sum = b;
          line_phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        rec_address = {rec_address[23:0], b};
        rec_sum = rec_sum + b;
        if (addr_left > 0) addr_left = addr_left - 3'd1;
        if (addr_left == 0) line_phase = (data_left != 0) ? PH_DATA : PH_CSUM;
      end
      PH_DATA: begin
        rec_sum = rec_sum + b;
        emit(KIND_DATA, b, data_pos, data_total, ST_OK);
        data_pos = data_pos + 8'd1;
        if (data_left > 0) data_left = data_left - 8'd1;
        if (data_left == 0) line_phase = PH_CSUM;
      end
      PH_CSUM: close_record((b == ~rec_sum) ? ST_OK : ST_CSUM);
      default: ;
    endcase
  endfunction

  function automatic string describe(out_item_t r);
    return $sformatf("kind=%0d byte=%h idx=%0d type=%0d addr=%h count=%0d status=%0d",
                     r.kind, r.data_byte, r.byte_index, r.record_type,
                     r.load_address, r.data_count, r.status);
  endfunction

  function automatic void push_char(logic [7:0] c, logic ls);
    in_item_t it;
    it.char_code = c;
    it.line_start = ls;
    pending_chars.push_back(it);
  endfunction

  function automatic void push_line(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void add_hex(logic [7:0] v);
    line_buf.push_back(hex_digit(v[7:4]));
    line_buf.push_back(hex_digit(v[3:0]));
  endfunction

  function automatic void build_record();
    logic [7:0] tchar;
    logic [7:0] sum;
    logic [7:0] v;
    int alen;
    int ndata;
    int cnt;
    int r;
    int pos;
    line_buf.delete();
    if ($urandom_range(0, 99) < 92) begin
      case ($urandom_range(0, 6))
        0: tchar = "0";
        1: tchar = "1";
        2: tchar = "2";
        3: tchar = "3";
        4: tchar = "7";
        5: tchar = "8";
        default: tchar = "9";
      endcase
    end else begin
      tchar = $urandom_range(0, 1) ? 8'($urandom_range("4", "6")) : 8'($urandom_range(0, 255));
    end
    alen = (tchar >= "0" && tchar <= "9") ? address_length(tchar - "0") : 0;
    if (alen == 0) alen = 2;
    r = $urandom_range(0, 99);
    if (r < 3) ndata = $urandom_range(56, MAX_DATA_BYTES);
    else if (r < 6) ndata = $urandom_range(MAX_DATA_BYTES + 1, MAX_DATA_BYTES + 6);
    else ndata = $urandom_range(0, 8);
    cnt = alen + 1 + ndata;
    if ($urandom_range(0, 99) < 4) cnt = $urandom_range(0, 255);
    line_buf.push_back(CHAR_S);
    line_buf.push_back(tchar);
    add_hex(8'(cnt));
    sum = 8'(cnt);
    repeat (alen + ndata) begin
      v = 8'($urandom_range(0, 255));
      add_hex(v);
      sum = sum + v;
    end
    v = ~sum;
    if ($urandom_range(0, 99) < 8) v = v ^ (8'd1 << $urandom_range(0, 7));
    add_hex(v);
    if ($urandom_range(0, 99) < 10)
      line_buf[$urandom_range(1, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 7) begin
      pos = $urandom_range(1, line_buf.size() - 1);
      while (line_buf.size() > pos) void'(line_buf.pop_back());
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
    end else if (r < 75) begin
      line_buf.push_back(CHAR_LF);
    end else if (r < 85) begin
      line_buf.push_back(8'($urandom_range(0, 255)));
    end
    foreach (line_buf[i]) push_char(line_buf[i], i == 0);
  endfunction

  function automatic void add_noise();
    push_char($urandom_range(0, 1) ? CHAR_S : 8'($urandom_range(0, 255)), 1'b1);
    repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (!chars.valid || char_accepted) begin
        if (gap_left > 0) begin
          chars.valid <= 1'b0;
          gap_left--;
        end else if (pending_chars.size() != 0) begin
          chars.valid <= 1'b1;
          chars.payload <= pending_chars.pop_front();
          gap_left = pick_gap();
        end else begin
          chars.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        results.ready <= 1'b0;
        stall_left--;
      end else begin
        results.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    char_accepted = 1'b0;
    if (!rst) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(40, 160);
      if (chars.valid && chars.ready) begin
        decode_char(chars.payload);
        chars_accepted++;
        char_accepted = 1'b1;
      end
      if (results.valid && results.ready) begin
        got = results.payload;
        if (awaited_results.size() == 0) begin
          if (error_count < REPORT_LIMIT)
            $display("%0t: unexpected result transaction: %s", $time, describe(got));
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.byte_index !== want.byte_index || got.record_type !== want.record_type ||
              got.load_address !== want.load_address ||
              got.data_count !== want.data_count || got.status !== want.status) begin
            if (error_count < REPORT_LIMIT) begin
              $display("%0t: result mismatch", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
            error_count++;
          end
        end
      end
      if (char_accepted || (results.valid && results.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    chars.valid = 1'b0;
    chars.payload = '0;
    results.ready = 1'b0;
    clear_record();

    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);
    push_line("SZ");
    push_line("S100");
    push_line("S2g");
    push_line("S9");
    push_char(CHAR_CR, 1'b0);
    push_line("S3");
    push_char("x", 1'b1);
    push_line("S80");
    push_line("S1040000ab50");
    push_char("q", 1'b0);

    while (pending_chars.size() < CHAR_TARGET) begin
      if ($urandom_range(0, 99) < 88) build_record();
      else add_noise();
    end
    chars_total = pending_chars.size();

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (chars_accepted == chars_total);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && awaited_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
